@@ rtl/core/modbus_rtu_request_framer_assert.svh @@
// Assertion macros for the Modbus RTU request framer checker.
// Each macro expects signals named clock and reset in the using scope.
`ifndef MODBUS_RTU_REQUEST_FRAMER_ASSERT_SVH
`define MODBUS_RTU_REQUEST_FRAMER_ASSERT_SVH

// Condition must hold on every clock outside reset.
`define MRRF_ASSERT_ALWAYS(name, expr, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Same-cycle implication.
`define MRRF_ASSERT_IMPLY(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define MRRF_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/mrrf_pkg.sv @@
// Shared types, constants and the CRC-16/Modbus byte update for the request framer.
// No dependencies.
package mrrf_pkg;

   localparam logic [7:0]  FC_WRITE_MULTIPLE = 8'h10;
   localparam logic [7:0]  FC_WRITE_SINGLE   = 8'h06;
   localparam logic [15:0] CRC_INIT          = 16'hFFFF;
   localparam logic [15:0] CRC_POLY          = 16'hA001;
   localparam logic [7:0]  MULTI_COUNT       = 8'h02;
   localparam logic [7:0]  MULTI_BYTE_COUNT  = 8'h04;

   localparam logic [3:0]  LEN_READ   = 4'd8;
   localparam logic [3:0]  LEN_MULTI  = 4'd13;
   localparam logic [3:0]  LEN_SINGLE = 4'd8;
   localparam logic [3:0]  LEN_BARE   = 4'd6;

   localparam logic MODE_READ = 1'b0;

   // Byte positions within a frame
   localparam logic [3:0] POS_SLAVE  = 4'd0;
   localparam logic [3:0] POS_FC     = 4'd1;
   localparam logic [3:0] POS_REG_HI = 4'd2;
   localparam logic [3:0] POS_REG_LO = 4'd3;
   localparam logic [3:0] POS_BODY0  = 4'd4;
   localparam logic [3:0] POS_BODY1  = 4'd5;
   localparam logic [3:0] POS_BODY2  = 4'd6;
   localparam logic [3:0] POS_BODY3  = 4'd7;
   localparam logic [3:0] POS_BODY4  = 4'd8;
   localparam logic [3:0] POS_BODY5  = 4'd9;

   typedef struct packed {
      logic        mode;
      logic [7:0]  function_code;
      logic [7:0]  unit_address;
      logic [15:0] register_number;
      logic [15:0] register_count;
      logic [31:0] write_value;
   } req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_byte;
   } rsp_type;

   typedef enum logic [1:0] {
      KIND_READ   = 2'd0,
      KIND_MULTI  = 2'd1,
      KIND_SINGLE = 2'd2,
      KIND_BARE   = 2'd3
   } frame_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SEND = 2'b10
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic       load;
      logic       emit;
      logic [3:0] index;
   } ctl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic slot_free;
      logic last_index;
   } dp_status_type;

   function automatic logic [15:0] crc_byte_update(input logic [15:0] crc,
                                                   input logic [7:0]  data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   function automatic logic [3:0] frame_length(input frame_kind_type kind);
      logic [3:0] len;
      unique case (kind)
         KIND_READ:   len = LEN_READ;
         KIND_MULTI:  len = LEN_MULTI;
         KIND_SINGLE: len = LEN_SINGLE;
         default:     len = LEN_BARE;
      endcase
      return len;
   endfunction

endpackage

@@ rtl/core/mrrf_ctrl.sv @@
// Sequencer for the request framer: accepts a request, then steps the byte index.
// Depends on mrrf_pkg.
module mrrf_ctrl
   import mrrf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output ctl_cmd_type   cmd
);

   state_type  state_ff, state_in;
   logic [3:0] index_ff, index_in;
   logic       accept;
   logic       emit;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign emit      = (state_ff == ST_SEND) && status.slot_free;

   always_comb begin
      state_in = state_ff;
      index_in = index_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SEND;
               index_in = '0;
            end
         end
         ST_SEND: begin
            if (emit) begin
               index_in = index_ff + 4'd1;
               if (status.last_index) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         index_ff <= '0;
      end else begin
         state_ff <= state_in;
         index_ff <= index_in;
      end
   end

   assign cmd.load  = accept;
   assign cmd.emit  = emit;
   assign cmd.index = index_ff;

endmodule

@@ rtl/core/mrrf_datapath.sv @@
// Request holding registers, frame byte select, running CRC and output register.
// Depends on mrrf_pkg.
module mrrf_datapath
   import mrrf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  req_type       req_data,
   input  ctl_cmd_type   cmd,
   output dp_status_type status,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_type       rsp_data
);

   frame_kind_type kind_ff, kind_in;
   logic [7:0]  slave_ff, fc_ff;
   logic [15:0] reg_addr_ff, count_ff, crc_ff;
   logic [31:0] value_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff;

   logic [3:0]  frame_len;
   logic        is_crc_lo, is_crc_hi;
   logic [7:0]  body_byte, next_byte;

   always_comb begin
      if (req_data.mode == MODE_READ) begin
         kind_in = KIND_READ;
      end else if (req_data.function_code == FC_WRITE_MULTIPLE) begin
         kind_in = KIND_MULTI;
      end else if (req_data.function_code == FC_WRITE_SINGLE) begin
         kind_in = KIND_SINGLE;
      end else begin
         kind_in = KIND_BARE;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff     <= kind_in;
         slave_ff    <= req_data.unit_address;
         fc_ff       <= req_data.function_code;
         reg_addr_ff <= req_data.register_number - 16'd1;   // one-based to wire address
         count_ff    <= req_data.register_count;
         value_ff    <= req_data.write_value;
      end
   end

   assign frame_len = frame_length(kind_ff);
   assign is_crc_hi = (cmd.index == frame_len - 4'd1);
   assign is_crc_lo = (cmd.index == frame_len - 4'd2);

   always_comb begin
      body_byte = 8'h00;
      case (kind_ff)
         KIND_READ:   body_byte = (cmd.index == POS_BODY0) ? count_ff[15:8] : count_ff[7:0];
         KIND_SINGLE: body_byte = (cmd.index == POS_BODY0) ? value_ff[15:8] : value_ff[7:0];
         KIND_MULTI: begin
            case (cmd.index)
               POS_BODY0: body_byte = 8'h00;
               POS_BODY1: body_byte = MULTI_COUNT;
               POS_BODY2: body_byte = MULTI_BYTE_COUNT;
               POS_BODY3: body_byte = value_ff[31:24];
               POS_BODY4: body_byte = value_ff[23:16];
               POS_BODY5: body_byte = value_ff[15:8];
               default:   body_byte = value_ff[7:0];
            endcase
         end
         default:     body_byte = 8'h00;
      endcase
   end

   always_comb begin
      if (is_crc_hi) begin
         next_byte = crc_ff[15:8];
      end else if (is_crc_lo) begin
         next_byte = crc_ff[7:0];
      end else begin
         case (cmd.index)
            POS_SLAVE:  next_byte = slave_ff;
            POS_FC:     next_byte = fc_ff;
            POS_REG_HI: next_byte = reg_addr_ff[15:8];
            POS_REG_LO: next_byte = reg_addr_ff[7:0];
            default:    next_byte = body_byte;
         endcase
      end
   end

   // CRC covers every byte ahead of the two CRC bytes
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         crc_ff <= CRC_INIT;
      end else if (cmd.emit && !is_crc_lo && !is_crc_hi) begin
         crc_ff <= crc_byte_update(crc_ff, next_byte);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff.frame_byte <= next_byte;
         rsp_data_ff.last_byte  <= is_crc_hi;
      end
   end

   assign status.slot_free  = !rsp_valid_ff || rsp_ready;
   assign status.last_index = is_crc_hi;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_data          = rsp_data_ff;

endmodule

@@ rtl/core/modbus_rtu_request_framer.sv @@
// Modbus RTU request framer: one request item in, 6, 8 or 13 frame byte items out.
// After a request is accepted the sequencer enters its send state; the first byte is then registered at the output.
// Throughput: one byte per cycle while rsp_ready is high, through the single output register;
// a new request is accepted once the byte sequencer has issued the last byte of a frame.
// Reset clears the sequencer and the output valid; no request is held across reset.
// Depends on mrrf_pkg, mrrf_ctrl, mrrf_datapath.
module modbus_rtu_request_framer
   import mrrf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   ctl_cmd_type   cmd;
   dp_status_type status;

   mrrf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mrrf_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

@@ rtl/core/mrrf_checker.sv @@
// Port-level checks for the request framer, bound to the top level.
// Depends on mrrf_pkg and modbus_rtu_request_framer_assert.svh.
`include "modbus_rtu_request_framer_assert.svh"

module mrrf_checker
   import mrrf_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // a stalled output item holds
   `MRRF_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_data), "rsp item changed while stalled")

   // busy right after taking a request
   `MRRF_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready,
      "req_ready high during frame")

   // when ready for a new request, only the closing byte may still wait
   `MRRF_ASSERT_IMPLY(a_idle_only_last, req_ready && rsp_valid, rsp_data.last_byte,
      "pending byte not last while idle")

   // a new frame never starts on top of an unfinished one
   `MRRF_ASSERT_NEXT(a_no_overlap, req_valid && req_ready,
      !rsp_valid || rsp_data.last_byte, "frame overlap")

endmodule

bind modbus_rtu_request_framer mrrf_checker u_checker (.*);
